/* hdl/nearest_cone_by_class_select_defines.svh */
// Assertion macros shared by the nearest cone selector.
`ifndef NEAREST_CONE_BY_CLASS_SELECT_DEFINES_SVH
`define NEAREST_CONE_BY_CLASS_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ncs_pkg.sv */
// Shared types and constants of the nearest cone selector.
package ncs_pkg;

    localparam int MAX_CONES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam int CLS_W = 3;
    localparam int IDX_W = 7;

    localparam logic [IDX_W-1:0] IDX_NONE = '1;

    localparam logic [CLS_W-1:0] CLASS_YELLOW       = 3'd1;
    localparam logic [CLS_W-1:0] CLASS_BLUE         = 3'd2;
    localparam logic [CLS_W-1:0] CLASS_ORANGE_SMALL = 3'd3;

    // Which tracker a cone goes to after classification.
    typedef enum logic [1:0] {
        SEL_NONE   = 2'd0,
        SEL_YELLOW = 2'd1,
        SEL_BLUE   = 2'd2,
        SEL_GATE   = 2'd3
    } t_sel;

    // Control part of one queued cone.
    typedef struct packed {
        t_sel             sel;
        logic [IDX_W-1:0] idx;
        logic             ovf;
        logic             last;
    } t_ncs_tag;

endpackage

/* hdl/ncs_cone_if.sv */
// Input channel carrying one detected cone per beat.
interface ncs_cone_if
    import ncs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic        [CLS_W-1:0]      cone_class;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         last;

    modport source (output valid, cone_class, pos_x, pos_y, last, input ready);
    modport sink   (input valid, cone_class, pos_x, pos_y, last, output ready);
endinterface

/* hdl/ncs_pick_if.sv */
// Output channel carrying the per-frame selection result.
interface ncs_pick_if
    import ncs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [IDX_W-1:0] nearest_blue;
    logic signed [IDX_W-1:0] nearest_yellow;
    logic signed [IDX_W-1:0] gate_first_index;
    logic signed [IDX_W-1:0] gate_second_index;
    logic                    overflow;

    modport source (output valid, nearest_blue, nearest_yellow, gate_first_index,
                    gate_second_index, overflow, input ready);
    modport sink   (input valid, nearest_blue, nearest_yellow, gate_first_index,
                    gate_second_index, overflow, output ready);
endinterface

/* hdl/nearest_cone_by_class_select.sv */
// Top level of the nearest cone selector: front end, queue and back end.
// The result register loads when the back end pops a frame's last beat from the queue.
// Throughput: one cone beat per cycle unless stalled, set by the back end's add-and-compare.
// A stalled result holds the back end, while the queue lets the front keep taking beats.
// Reset is synchronous and active low; it empties the queue and clears every tracker.
`include "nearest_cone_by_class_select_defines.svh"

module nearest_cone_by_class_select
    import ncs_pkg::*;
#(
    parameter int MAX_CONES  = MAX_CONES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ncs_cone_if.sink   i_cone,
    ncs_pick_if.source o_pick
);

    // Each squared coordinate needs one bit less than twice the coordinate width.
    localparam int SW    = 2 * COORD_BITS - 1;
    localparam int QW    = $bits(t_ncs_tag) + 2 * SW;
    localparam int QUEUE = 4;

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    t_ncs_tag      w_front_tag;
    logic [SW-1:0] w_front_sqx;
    logic [SW-1:0] w_front_sqy;
    t_ncs_tag      w_head_tag;
    logic [SW-1:0] w_head_sqx;
    logic [SW-1:0] w_head_sqy;

    // The front end numbers each beat in its frame, flags beats past the
    // frame limit and registers both squared coordinates.
    ncs_front #(
        .MAX_CONES  (MAX_CONES),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cone  (i_cone),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_tag   (w_front_tag),
        .o_sqx   (w_front_sqx),
        .o_sqy   (w_front_sqy)
    );

    // The queue decouples the two halves so each can stall on its own.
    ncs_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_tag, w_front_sqx, w_front_sqy}),
        .i_pop   (w_pop),
        .o_data  ({w_head_tag, w_head_sqx, w_head_sqy}),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // The back end sums the squares, updates the per-class trackers and
    // loads the result register on the last beat of a frame.
    ncs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_tag   (w_head_tag),
        .i_sqx   (w_head_sqx),
        .i_sqy   (w_head_sqy),
        .o_pop   (w_pop),
        .o_pick  (o_pick)
    );

    // Taking the last beat of a frame must present a result next cycle.
    `NCS_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_pop && w_head_tag.last, o_pick.valid, "last beat gave no result")
    // A result only appears because a last beat was taken.
    `NCS_ASSERT_IMP(a_result_from_last, i_clk, i_rst_n, $rose(o_pick.valid), $past(w_pop && w_head_tag.last), "result without last beat")
    // A result still waiting must hold the back end.
    `NCS_ASSERT_IMP(a_hold_stalls_back, i_clk, i_rst_n, o_pick.valid && !o_pick.ready, !w_pop, "back end ran over a held result")

endmodule

/* hdl/ncs_front.sv */
// Front end: numbers each cone in its frame, classifies it and squares its coordinates.
module ncs_front
    import ncs_pkg::*;
#(
    parameter int MAX_CONES  = MAX_CONES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SW = 2 * COORD_BITS - 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ncs_cone_if.sink        i_cone,
    input  logic            i_full,
    output logic            o_push,
    output t_ncs_tag        o_tag,
    output logic [SW-1:0]   o_sqx,
    output logic [SW-1:0]   o_sqy
);

    localparam int CW = $clog2(MAX_CONES + 1);

    logic                    r_valid;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    t_ncs_tag                r_tag;
    t_ncs_tag                n_tag;
    logic [SW-1:0]           r_sqx;
    logic [SW-1:0]           r_sqy;
    logic [COORD_BITS-1:0]   w_mag_x;
    logic [COORD_BITS-1:0]   w_mag_y;
    logic [2*COORD_BITS-1:0] w_prod_x;
    logic [2*COORD_BITS-1:0] w_prod_y;
    logic [CW+IDX_W-1:0]     w_idx_ext;
    logic                    w_accept;
    logic                    w_ovf;

    assign o_push         = r_valid && !i_full;
    assign i_cone.ready   = !r_valid || !i_full;
    assign w_accept       = i_cone.valid && i_cone.ready;
    assign w_ovf          = (r_count >= CW'(MAX_CONES));
    assign w_idx_ext      = {{IDX_W{1'b0}}, r_count};

    // Magnitudes are unsigned, so the most negative value still fits.
    assign w_mag_x  = i_cone.pos_x[COORD_BITS-1] ? (~i_cone.pos_x + 1'b1) : i_cone.pos_x;
    assign w_mag_y  = i_cone.pos_y[COORD_BITS-1] ? (~i_cone.pos_y + 1'b1) : i_cone.pos_y;
    assign w_prod_x = w_mag_x * w_mag_x;
    assign w_prod_y = w_mag_y * w_mag_y;

    always_comb begin
        n_tag.idx  = w_idx_ext[IDX_W-1:0];
        n_tag.ovf  = w_ovf;
        n_tag.last = i_cone.last;
        n_tag.sel  = SEL_NONE;
        if (!w_ovf) begin
            if (i_cone.cone_class == CLASS_BLUE) begin
                n_tag.sel = SEL_BLUE;
            end else if (i_cone.cone_class == CLASS_YELLOW) begin
                n_tag.sel = SEL_YELLOW;
            end else if (i_cone.cone_class == CLASS_ORANGE_SMALL) begin
                n_tag.sel = SEL_GATE;
            end
        end
        if (i_cone.last) begin
            n_count = '0;
        end else if (w_ovf) begin
            n_count = r_count;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag <= n_tag;
            r_sqx <= w_prod_x[SW-1:0];
            r_sqy <= w_prod_y[SW-1:0];
        end
    end

    assign o_tag = r_tag;
    assign o_sqx = r_sqx;
    assign o_sqy = r_sqy;

endmodule

/* hdl/ncs_fifo.sv */
// Small register queue between the front and back ends.
module ncs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr;
    logic [AW:0]      r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW-1:0] == r_rd[AW-1:0]) && (r_wr[AW] != r_rd[AW]);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

/* hdl/ncs_back.sv */
// Back end: keeps the nearest cones of the frame and emits the result on the last beat.
module ncs_back
    import ncs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SW = 2 * COORD_BITS - 1,
    localparam int DW = 2 * COORD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  t_ncs_tag      i_tag,
    input  logic [SW-1:0] i_sqx,
    input  logic [SW-1:0] i_sqy,
    output logic          o_pop,
    ncs_pick_if.source    o_pick
);

    logic [DW-1:0]    w_dist;

    logic [DW-1:0]    r_blue_d, n_blue_d, r_yel_d, n_yel_d;
    logic [DW-1:0]    r_g1_d, n_g1_d, r_g2_d, n_g2_d;
    logic [IDX_W-1:0] r_blue_i, n_blue_i, r_yel_i, n_yel_i;
    logic [IDX_W-1:0] r_g1_i, n_g1_i, r_g2_i, n_g2_i;
    logic             r_blue_v, n_blue_v, r_yel_v, n_yel_v;
    logic             r_g1_v, n_g1_v, r_g2_v, n_g2_v;
    logic             r_ovf, n_ovf;

    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_blue, r_o_yel, r_o_g1, r_o_g2;
    logic             r_o_ovf;

    assign o_pop  = !i_empty && (!r_o_valid || o_pick.ready);
    assign w_dist = {1'b0, i_sqx} + {1'b0, i_sqy};

    always_comb begin
        n_blue_d = r_blue_d;  n_blue_i = r_blue_i;  n_blue_v = r_blue_v;
        n_yel_d  = r_yel_d;   n_yel_i  = r_yel_i;   n_yel_v  = r_yel_v;
        n_g1_d   = r_g1_d;    n_g1_i   = r_g1_i;    n_g1_v   = r_g1_v;
        n_g2_d   = r_g2_d;    n_g2_i   = r_g2_i;    n_g2_v   = r_g2_v;
        n_ovf    = r_ovf | i_tag.ovf;
        // Strict less-than keeps the earlier cone on a tie.
        case (i_tag.sel)
            SEL_BLUE: begin
                if (!r_blue_v || w_dist < r_blue_d) begin
                    n_blue_d = w_dist;  n_blue_i = i_tag.idx;  n_blue_v = 1'b1;
                end
            end
            SEL_YELLOW: begin
                if (!r_yel_v || w_dist < r_yel_d) begin
                    n_yel_d = w_dist;  n_yel_i = i_tag.idx;  n_yel_v = 1'b1;
                end
            end
            SEL_GATE: begin
                if (!r_g1_v || w_dist < r_g1_d) begin
                    n_g2_d = r_g1_d;  n_g2_i = r_g1_i;     n_g2_v = r_g1_v;
                    n_g1_d = w_dist;  n_g1_i = i_tag.idx;  n_g1_v = 1'b1;
                end else if (!r_g2_v || w_dist < r_g2_d) begin
                    n_g2_d = w_dist;  n_g2_i = i_tag.idx;  n_g2_v = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blue_v  <= 1'b0;
            r_yel_v   <= 1'b0;
            r_g1_v    <= 1'b0;
            r_g2_v    <= 1'b0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_tag.last) begin
                    r_blue_v  <= 1'b0;
                    r_yel_v   <= 1'b0;
                    r_g1_v    <= 1'b0;
                    r_g2_v    <= 1'b0;
                    r_ovf     <= 1'b0;
                    r_o_valid <= 1'b1;
                end else begin
                    r_blue_v  <= n_blue_v;
                    r_yel_v   <= n_yel_v;
                    r_g1_v    <= n_g1_v;
                    r_g2_v    <= n_g2_v;
                    r_ovf     <= n_ovf;
                    r_o_valid <= r_o_valid && !o_pick.ready;
                end
            end else if (o_pick.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_blue_d <= n_blue_d;  r_blue_i <= n_blue_i;
            r_yel_d  <= n_yel_d;   r_yel_i  <= n_yel_i;
            r_g1_d   <= n_g1_d;    r_g1_i   <= n_g1_i;
            r_g2_d   <= n_g2_d;    r_g2_i   <= n_g2_i;
            if (i_tag.last) begin
                r_o_blue <= n_blue_v ? n_blue_i : IDX_NONE;
                r_o_yel  <= n_yel_v  ? n_yel_i  : IDX_NONE;
                r_o_g1   <= n_g1_v   ? n_g1_i   : IDX_NONE;
                r_o_g2   <= n_g2_v   ? n_g2_i   : IDX_NONE;
                r_o_ovf  <= n_ovf;
            end
        end
    end

    assign o_pick.valid             = r_o_valid;
    assign o_pick.nearest_blue      = r_o_blue;
    assign o_pick.nearest_yellow    = r_o_yel;
    assign o_pick.gate_first_index  = r_o_g1;
    assign o_pick.gate_second_index = r_o_g2;
    assign o_pick.overflow          = r_o_ovf;

endmodule
